[sv/wrm_pkg.sv]
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types and constants of the windowed rate meter: field widths,
// command codes, the rate scale and the divider status bundle.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int DELTA_W       = 32;
  localparam int RATE_W        = 38;
  localparam int COUNT_W       = 7;
  localparam int DEPTH_DEFAULT = 64;

  // rate = count * 1e9 * 2^FRAC_W / sum
  localparam int                FRAC_W    = 8;
  localparam int                NS_W      = 30;
  localparam logic [NS_W-1:0]   NS_PER_S  = 30'd1000000000;
  localparam logic [RATE_W-1:0] RATE_MAX  = 38'd256000000000;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/wrm_div.sv]
// ----------------------------------------------------------------------------
// wrm_div
// Bit-serial restoring divider: one quotient bit per cycle, numerator
// shifted in msb first. Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module wrm_div #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 38,
  parameter int QUO_W = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    numer_i,
  input  logic [DEN_W-1:0]    denom_i,
  output logic [QUO_W-1:0]    quot_o,
  output wrm_pkg::div_status_t status_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numer_i;
      den_q <= denom_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      // high quotient bits are always zero, so they fall off the top
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign quot_o        = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

[sv/windowed_rate_meter.sv]
// ----------------------------------------------------------------------------
// windowed_rate_meter
// Average event rate over a sliding window of the last DEPTH intervals.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one item is either an interval in
// ns (command_i = record) or a clear command. Output channel (out_valid_o /
// out_stall_i): one result per item, rate_fixed_o = count * 256e9 / sum
// (events per second, 8 fraction bits, 0 for an empty window) and
// valid_count_o = number of non-zero intervals held.
// One item is worked on at a time. A record item passes the update, start
// and divide states before its result is loaded; NUM_W = clog2(DEPTH+1) + 38
// numerator bits pass the bit-serial divider, one quotient bit per cycle.
// A clear item skips the divider and goes straight to the done state; a
// record that leaves the window empty skips it after the update and start states.
// A finished result sits in the output register while the next item is
// taken; a result that finds the output still stalled waits in place and
// holds the input stalled until it moves.
// Reset empties the window at once: a fill count marks which ring slots have
// been written since the last clear, so no clearing pass is needed and the
// block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
module windowed_rate_meter #(
  parameter int DEPTH = wrm_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [wrm_pkg::DELTA_W-1:0] delta_ns_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wrm_pkg::RATE_W-1:0]  rate_fixed_o,
  output logic [wrm_pkg::COUNT_W-1:0] valid_count_o
);

  localparam int DeltaW = wrm_pkg::DELTA_W;
  localparam int RateW  = wrm_pkg::RATE_W;
  localparam int CountW = wrm_pkg::COUNT_W;
  localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int SumW   = DeltaW + IdxW;
  localparam int ProdW  = CntW + wrm_pkg::NS_W;
  localparam int NumW   = ProdW + wrm_pkg::FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [DeltaW-1:0] ring_q [DEPTH];
  logic [DeltaW-1:0] rd_data_q;
  logic [DeltaW-1:0] delta_q;
  logic [IdxW-1:0]   widx_q;
  logic [CntW-1:0]   fill_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   count_q;
  logic              zero_q;
  logic              out_valid_q;
  logic [RateW-1:0]  rate_q;
  logic [CountW-1:0] out_count_q;

  logic              in_accept;
  logic              ring_we;
  logic [DeltaW-1:0] old_val;
  logic [SumW-1:0]   sum_d;
  logic [CntW-1:0]   count_d;
  logic [ProdW-1:0]  product;
  logic [NumW-1:0]   numer;
  logic              div_start;
  logic [RateW-1:0]  quot;
  logic              out_load;
  wrm_pkg::div_status_t div_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ring_we    = (state_q == S_UPDATE);
  assign div_start  = (state_q == S_START) && (count_q != '0);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // slots at or beyond the fill count have not been written since clear
  assign old_val = (CntW'(widx_q) < fill_q) ? rd_data_q : '0;

  always_comb begin
    sum_d   = sum_q - SumW'(old_val) + SumW'(delta_q);
    count_d = count_q;
    if (old_val != '0) count_d = count_d - 1'b1;
    if (delta_q != '0) count_d = count_d + 1'b1;
  end

  assign product = ProdW'(count_q) * ProdW'(wrm_pkg::NS_PER_S);
  assign numer   = {product, {wrm_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[widx_q] <= delta_q;
    end
    if (in_accept) begin
      rd_data_q <= ring_q[widx_q];
    end
  end

  wrm_div #(
    .NUM_W (NumW),
    .DEN_W (SumW),
    .QUO_W (RateW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (numer),
    .denom_i  (sum_q),
    .quot_o   (quot),
    .status_o (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delta_q     <= '0;
      widx_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rate_q      <= '0;
      out_count_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (command_i == wrm_pkg::CMD_CLEAR) begin
              widx_q  <= '0;
              fill_q  <= '0;
              sum_q   <= '0;
              count_q <= '0;
              zero_q  <= 1'b1;
              state_q <= S_DONE;
            end else begin
              delta_q <= delta_ns_i;
              state_q <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          sum_q   <= sum_d;
          count_q <= count_d;
          widx_q  <= (widx_q == IdxW'(DEPTH - 1)) ? '0 : widx_q + 1'b1;
          if (fill_q != CntW'(DEPTH)) begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_START;
        end
        S_START: begin
          zero_q  <= (count_q == '0);
          state_q <= (count_q == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            rate_q      <= zero_q ? '0 : quot;
            out_count_q <= CountW'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rate_fixed_o  = rate_q;
  assign valid_count_o = out_count_q;

endmodule

[sv/wrm_checker.sv]
// ----------------------------------------------------------------------------
// wrm_checker
// Port-level checks of the windowed rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module wrm_checker #(
  parameter int DEPTH = wrm_pkg::DEPTH_DEFAULT
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        command_i,
  input logic [wrm_pkg::DELTA_W-1:0] delta_ns_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [wrm_pkg::RATE_W-1:0]  rate_fixed_o,
  input logic [wrm_pkg::COUNT_W-1:0] valid_count_o
);

  localparam bit CountFits = (DEPTH < 128);

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(command_i) && $stable(delta_ns_i))
    else $error("stalled input item changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(rate_fixed_o) && $stable(valid_count_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // empty window gives zero rate, a non-empty one a non-zero rate
  a_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountFits |-> ((valid_count_o == '0) == (rate_fixed_o == '0)))
    else $error("rate and count disagree on empty window");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && CountFits |->
      (int'(valid_count_o) <= DEPTH) && (rate_fixed_o <= wrm_pkg::RATE_MAX))
    else $error("result out of range");

endmodule

bind windowed_rate_meter wrm_checker #(.DEPTH(DEPTH)) u_wrm_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_rate_meter. Interval and clear items go
// in through the valid/stall input channel. A model of the window in the
// bench predicts the rate and the count for every accepted item, and each
// result is compared with the oldest prediction. Both sides idle at random.
// One long output hold-off fills the block, and one pause waits until the
// output side has caught up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = wrm_pkg::DEPTH_DEFAULT;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [wrm_pkg::RATE_W-1:0]  rate;
    logic [wrm_pkg::COUNT_W-1:0] count;
  } rate_result_t;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  wrm_pkg::cmd_e                command   = wrm_pkg::CMD_RECORD;
  logic [wrm_pkg::DELTA_W-1:0]  delta_ns  = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [wrm_pkg::RATE_W-1:0]   rate_fixed;
  logic [wrm_pkg::COUNT_W-1:0]  valid_count;

  // window model
  logic [wrm_pkg::DELTA_W-1:0]  interval_ring [WINDOW] = '{default: '0};
  int unsigned                  ring_wr      = 0;
  longint unsigned              interval_sum = 0;
  int unsigned                  nonzero_cnt  = 0;
  rate_result_t                 rate_expect_q [$];

  int unsigned         error_cnt       = 0;
  bit                  tx_idle_en      = 1'b1;
  bit                  rx_idle_en      = 1'b1;
  int unsigned         stall_burst_req = 0;
  int unsigned         burst_left      = 0;
  int unsigned         quiet_cycles    = 0;

  windowed_rate_meter uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .delta_ns_i    (delta_ns),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .rate_fixed_o  (rate_fixed),
    .valid_count_o (valid_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void window_predict(wrm_pkg::cmd_e cmd,
                                         logic [wrm_pkg::DELTA_W-1:0] delta);
    rate_result_t                res;
    logic [wrm_pkg::DELTA_W-1:0] old_val;
    longint unsigned             scaled;
    if (cmd == wrm_pkg::CMD_CLEAR) begin
      foreach (interval_ring[i]) interval_ring[i] = '0;
      ring_wr      = 0;
      interval_sum = 0;
      nonzero_cnt  = 0;
    end else begin
      old_val = interval_ring[ring_wr];
      if (old_val != '0) begin
        interval_sum -= old_val;
        nonzero_cnt--;
      end
      if (delta != '0) begin
        interval_sum += delta;
        nonzero_cnt++;
      end
      interval_ring[ring_wr] = delta;
      ring_wr = (ring_wr + 1) % WINDOW;
    end
    res.count = nonzero_cnt[wrm_pkg::COUNT_W-1:0];
    if (nonzero_cnt == 0 || interval_sum == 0) begin
      res.rate = '0;
    end else begin
      scaled   = 64'(nonzero_cnt) * 64'(wrm_pkg::RATE_MAX);
      res.rate = wrm_pkg::RATE_W'(scaled / interval_sum);
    end
    rate_expect_q.push_back(res);
  endfunction

  // realistic frame intervals mixed with zeros, near-maximum extremes, tiny intervals and raw noise
  function automatic logic [wrm_pkg::DELTA_W-1:0] pick_interval();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 16) begin
      return {wrm_pkg::DELTA_W{1'b1}} - wrm_pkg::DELTA_W'($urandom_range(0, 3));
    end
    if (sel < 40) return wrm_pkg::DELTA_W'($urandom_range(1000000, 100000000));
    if (sel < 60) return wrm_pkg::DELTA_W'($urandom_range(1, 1000));
    return wrm_pkg::DELTA_W'($urandom());
  endfunction

  task automatic offer_interval(wrm_pkg::cmd_e cmd,
                                logic [wrm_pkg::DELTA_W-1:0] delta);
    if (tx_idle_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    delta_ns <= delta;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    window_predict(cmd, delta);
  endtask

  task automatic test_directed();
    offer_interval(wrm_pkg::CMD_RECORD, '0);            // zero into an empty window
    offer_interval(wrm_pkg::CMD_RECORD, 32'd1);         // fastest possible rate
    offer_interval(wrm_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    offer_interval(wrm_pkg::CMD_RECORD, '0);
    offer_interval(wrm_pkg::CMD_CLEAR, 32'hFFFF_FFFF);  // delta ignored on clear
    offer_interval(wrm_pkg::CMD_CLEAR, '0);             // clear of an empty window
    offer_interval(wrm_pkg::CMD_RECORD, 32'd16666667);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd16666666);
    offer_interval(wrm_pkg::CMD_RECORD, 32'h8000_0000);
    offer_interval(wrm_pkg::CMD_RECORD, 32'h7FFF_FFFF);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd1000000000);
    offer_interval(wrm_pkg::CMD_RECORD, 32'h5555_5555);
    offer_interval(wrm_pkg::CMD_RECORD, 32'hAAAA_AAAA);
    offer_interval(wrm_pkg::CMD_CLEAR, 32'h1234_5678);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd3);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd7);
    offer_interval(wrm_pkg::CMD_CLEAR, '0);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd1000000);
  endtask

  // full windows of the largest and smallest intervals, then let zeros
  // overwrite every entry so the window empties by wrapping
  task automatic test_window_extremes();
    repeat (WINDOW) offer_interval(wrm_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    repeat (WINDOW) offer_interval(wrm_pkg::CMD_RECORD, 32'd1);
    repeat (WINDOW) offer_interval(wrm_pkg::CMD_RECORD, '0);
    offer_interval(wrm_pkg::CMD_RECORD, 32'd1);
    offer_interval(wrm_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned run_left;
    run_left = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        offer_interval(wrm_pkg::CMD_CLEAR, wrm_pkg::DELTA_W'($urandom()));
        run_left = $urandom_range(1, 150);
      end else begin
        run_left--;
        if ($urandom_range(0, 99) < 2) begin
          offer_interval(wrm_pkg::CMD_CLEAR, wrm_pkg::DELTA_W'($urandom()));
        end else begin
          offer_interval(wrm_pkg::CMD_RECORD, pick_interval());
        end
      end
    end
  endtask

  // output held off while items keep coming, so the input side backs up
  task automatic test_backpressure();
    tx_idle_en      = 1'b0;
    stall_burst_req = 300;
    repeat (12) offer_interval(wrm_pkg::CMD_RECORD, pick_interval());
    tx_idle_en      = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) offer_interval(wrm_pkg::CMD_RECORD, pick_interval());
    in_valid <= 1'b0;
    @(posedge clk);
    while (rate_expect_q.size() != 0) @(posedge clk);
    repeat (20) offer_interval(wrm_pkg::CMD_RECORD, pick_interval());
  endtask

  task automatic test_steady_flow(int unsigned n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n_items) offer_interval(wrm_pkg::CMD_RECORD, pick_interval());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (stall_burst_req != 0) begin
      burst_left      = stall_burst_req;
      stall_burst_req = 0;
    end
    if (burst_left != 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin : check_results
    rate_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rate_expect_q.size() == 0) begin
        $display("%0t: result with no item pending, rate %0d count %0d",
                 $time, rate_fixed, valid_count);
        error_cnt++;
      end else begin
        want = rate_expect_q.pop_front();
        if (rate_fixed !== want.rate) begin
          $display("%0t: rate_fixed mismatch, expected %0d, actual %0d",
                   $time, want.rate, rate_fixed);
          error_cnt++;
        end
        if (valid_count !== want.count) begin
          $display("%0t: valid_count mismatch, expected %0d, actual %0d",
                   $time, want.count, valid_count);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_window_extremes();
    test_random_mix(460);
    test_backpressure();
    test_drain_pause();
    test_steady_flow(130);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rate_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0 && rate_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wrm_pkg.sv
sv/wrm_div.sv
sv/windowed_rate_meter.sv
sv/wrm_checker.sv
tb/testbench.sv
